@@ sv/bayer_rggb_bilinear_demosaic_defines.svh @@
// Assertion macros shared by the demosaic RTL.
// Expects aclk and aresetn in the scope of use; no other dependencies.
`ifndef BAYER_RGGB_BILINEAR_DEMOSAIC_DEFINES_SVH
`define BAYER_RGGB_BILINEAR_DEMOSAIC_DEFINES_SVH

// same-cycle implication, reset masked
`define BDM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, reset masked
`define BDM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/bdm_pkg.sv @@
// Shared types and constants of the bilinear RGGB demosaic.
// No dependencies; used by every module of the block.
package bdm_pkg;

    localparam int PIX_W         = 8;
    localparam int VSUM_W        = PIX_W + 1;
    localparam int COORD_W       = 12;
    localparam int CFG_W         = 13;
    localparam int CFG_IDX_W     = 4;
    localparam int MAX_WIDTH_DEF = 4096;
    localparam int MAX_HEIGHT    = 4096;
    localparam int RESET_WIDTH   = 640;
    localparam int RESET_HEIGHT  = 480;
    localparam int OQ_DEPTH      = 8;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

    // one window column: previous-previous row, previous row, current row
    typedef struct packed {
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
        logic [PIX_W-1:0] bot;
    } col_t;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } rgb_t;

endpackage

@@ sv/bdm_ram.sv @@
// Generic simple RAM: one write port, two registered read ports, write-first.
// No dependencies beyond bdm_pkg defaults.
module bdm_ram #(
    parameter int WIDTH = bdm_pkg::PIX_W,
    parameter int DEPTH = bdm_pkg::MAX_WIDTH_DEF,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr_a,
    output logic [WIDTH-1:0] rd_data_a,
    input  logic [AW-1:0]    rd_addr_b,
    output logic [WIDTH-1:0] rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= (wr_en && (wr_addr == rd_addr_a)) ? wr_data : mem[rd_addr_a];
        rd_data_b <= (wr_en && (wr_addr == rd_addr_b)) ? wr_data : mem[rd_addr_b];
    end

endmodule

@@ sv/bdm_cell.sv @@
// One column cell of the 3x3 window: holds a column, shifts or loads, and
// gives the vertical pair sum. Depends on bdm_pkg.
module bdm_cell (
    input  logic                       aclk,
    input  logic                       i_en,
    input  logic                       i_load,
    input  bdm_pkg::col_t              i_load_col,
    input  bdm_pkg::col_t              i_shift_col,
    output bdm_pkg::col_t              o_col,
    output logic [bdm_pkg::VSUM_W-1:0] o_vsum
);

    bdm_pkg::col_t col_reg;
    bdm_pkg::col_t col_next;

    always_comb begin
        col_next = col_reg;
        if (i_en) begin
            col_next = i_load ? i_load_col : i_shift_col;
        end
    end

    always_ff @(posedge aclk) begin
        col_reg <= col_next;
    end

    assign o_col  = col_reg;
    assign o_vsum = {1'b0, col_reg.top} + {1'b0, col_reg.bot};

endmodule

@@ sv/bdm_interp.sv @@
// Bilinear RGGB interpolation of one pixel from three window columns.
// Combinational; depends on bdm_pkg.
module bdm_interp (
    input  bdm_pkg::col_t              i_left,
    input  bdm_pkg::col_t              i_center,
    input  bdm_pkg::col_t              i_right,
    input  logic [bdm_pkg::VSUM_W-1:0] i_left_vsum,
    input  logic [bdm_pkg::VSUM_W-1:0] i_center_vsum,
    input  logic [bdm_pkg::VSUM_W-1:0] i_right_vsum,
    input  logic                       i_x_odd,
    input  logic                       i_y_odd,
    output bdm_pkg::rgb_t              o_rgb
);

    logic [bdm_pkg::VSUM_W:0]       orth;
    logic [bdm_pkg::VSUM_W:0]       diag;
    logic [bdm_pkg::VSUM_W-1:0]     hpair;
    logic [bdm_pkg::PIX_W-1:0]      q_orth;
    logic [bdm_pkg::PIX_W-1:0]      q_diag;
    logic [bdm_pkg::PIX_W-1:0]      m_hor;
    logic [bdm_pkg::PIX_W-1:0]      m_ver;

    always_comb begin
        orth   = {1'b0, i_center_vsum} + {2'b00, i_left.mid} + {2'b00, i_right.mid};
        diag   = {1'b0, i_left_vsum} + {1'b0, i_right_vsum};
        hpair  = {1'b0, i_left.mid} + {1'b0, i_right.mid};
        q_orth = bdm_pkg::PIX_W'((orth + 2'd2) >> 2);
        q_diag = bdm_pkg::PIX_W'((diag + 2'd2) >> 2);
        m_hor  = bdm_pkg::PIX_W'((hpair + 1'b1) >> 1);
        m_ver  = bdm_pkg::PIX_W'((i_center_vsum + 1'b1) >> 1);

        unique case ({i_y_odd, i_x_odd})
            2'b00: begin
                o_rgb = '{red: i_center.mid, green: q_orth, blue: q_diag};
            end
            2'b11: begin
                o_rgb = '{red: q_diag, green: q_orth, blue: i_center.mid};
            end
            2'b01: begin
                o_rgb = '{red: m_hor, green: i_center.mid, blue: m_ver};
            end
            default: begin
                o_rgb = '{red: m_ver, green: i_center.mid, blue: m_hor};
            end
        endcase
    end

endmodule

@@ sv/bayer_rggb_bilinear_demosaic.sv @@
// Bilinear demosaic for an RGGB Bayer stream. Raw bytes come in raster order
// on the s_ side (tuser low = pixel, tuser high = drain tick); while row y
// arrives, RGB for row y-1 leaves on the m_ side, edges clamped. The last
// pixel of a row gives two beats (columns W-2 and W-1); after the final row,
// drain ticks emit that row one pixel per tick, tlast on its final pixel.
// Pixels sent while the drain is pending, and drain ticks with none pending,
// are taken and give nothing. While s_tready is high the block takes one
// beat per clock: a pixel beat does one read and one write per line store,
// a drain tick two reads, and a chain of three column cells holds the 3x3
// window. st1_reg and st2_reg feed an eight-entry result queue that parts
// the sides, and s_tready drops while queued plus in-flight results leave
// fewer than two free entries: after a few beats with m_tready low, or,
// once the extra row-end beats of unbroken back-to-back rows fill the queue,
// for one clock per row end. A frame-size write restarts the frame. Depends
// on bdm_pkg, the cell, interp and RAM modules, and the defines header.
`include "bayer_rggb_bilinear_demosaic_defines.svh"

module bayer_rggb_bilinear_demosaic #(
    parameter int MAX_WIDTH = bdm_pkg::MAX_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // config write channel
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bdm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bdm_pkg::CFG_W-1:0]     cfg_data,
    // raw Bayer input
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // [7:0] raw_value
    input  logic                          s_tuser,   // [0] req_type
    // RGB output
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [47:0]                   m_tdata,   // red, green, blue, out_col, out_row
    output logic                          m_tlast    // frame_end
);

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int CW     = bdm_pkg::COORD_W;
    localparam int PW     = bdm_pkg::PIX_W;
    localparam int VW     = bdm_pkg::VSUM_W;
    localparam int EW     = (COL_W + 1 > bdm_pkg::CFG_W) ? COL_W + 1 : bdm_pkg::CFG_W;
    localparam int RST_W  = (bdm_pkg::RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH
                                                                : bdm_pkg::RESET_WIDTH;
    localparam int QD     = bdm_pkg::OQ_DEPTH;
    localparam int QA     = $clog2(QD);

    typedef struct packed {
        logic             pix;
        logic             drn;
        logic             first;
        logic             top_dup;
        logic [COL_W-1:0] x;
        logic [PW-1:0]    raw;
        logic             a_en;
        logic             b_en;
        logic             lc;
        logic             fe;
        logic [CW-1:0]    a_col;
        logic [CW-1:0]    a_row;
        logic [CW-1:0]    b_col;
    } stage_t;

    typedef struct packed {
        bdm_pkg::rgb_t rgb;
        logic [CW-1:0] col;
        logic [CW-1:0] row;
        logic          fe;
    } res_t;

    // control state
    logic [COL_W-1:0] col_reg, col_next;
    logic [CW-1:0]    row_reg, row_next;
    logic [COL_W-1:0] dcol_reg, dcol_next;
    logic             drain_pending_reg, drain_pending_next;
    logic [COL_W-1:0] wlast_reg, wlast_next;
    logic [CW-1:0]    hlast_reg, hlast_next;
    stage_t           st1_reg, st1_next;
    stage_t           st2_reg;

    logic [QA-1:0]    oq_wr_reg, oq_rd_reg;
    logic [QA:0]      oq_count_reg;
    res_t             oq_mem_reg [QD];

    // stage 0 decode
    logic             s_acc, pix_go, drn_go, cfg_hit, row_end, drain_last;
    logic [COL_W-1:0] dxp;
    logic [EW-1:0]    fw_ext;
    logic [bdm_pkg::CFG_W-1:0] fh;

    // line stores
    logic [PW-1:0]    old_a, new_a, old_b, new_b;
    logic [COL_W-1:0] rd_addr_a;
    logic [PW-1:0]    s1_top, s1_mid;

    // window
    bdm_pkg::col_t    s1_col_a, s1_col_b;
    bdm_pkg::col_t    c0, c1, c2;
    logic [VW-1:0]    v0, v1, v2;
    logic             win_en, win_load;

    // results
    bdm_pkg::rgb_t    rgb_a, rgb_b;
    res_t             res_a, res_b;
    logic [1:0]       push_n, n1, n2;
    logic             oq_pop;
    logic [QA:0]      in_flight;

    assign cfg_ready  = 1'b1;
    assign cfg_hit    = cfg_valid && cfg_ready &&
                        (cfg_index == bdm_pkg::REG_FRAME_WIDTH ||
                         cfg_index == bdm_pkg::REG_FRAME_HEIGHT);

    assign n1         = {1'b0, st1_reg.a_en} + {1'b0, st1_reg.b_en};
    assign n2         = {1'b0, st2_reg.a_en} + {1'b0, st2_reg.b_en};
    assign in_flight  = oq_count_reg + (QA+1)'(n1) + (QA+1)'(n2);
    assign s_tready   = ((QA+2)'(in_flight) + (QA+2)'(2)) <= (QA+2)'(QD);

    assign s_acc      = s_tvalid && s_tready;
    assign pix_go     = s_acc && !s_tuser && !drain_pending_reg;
    assign drn_go     = s_acc && s_tuser && drain_pending_reg;
    assign row_end    = (col_reg == wlast_reg);
    assign drain_last = (dcol_reg == wlast_reg);
    assign dxp        = drain_last ? dcol_reg : dcol_reg + 1'b1;
    assign rd_addr_a  = drain_pending_reg ? dxp : col_reg;

    assign fw_ext     = EW'(cfg_data);
    assign fh         = cfg_data;

    always_comb begin
        col_next           = col_reg;
        row_next           = row_reg;
        dcol_next          = dcol_reg;
        drain_pending_next = drain_pending_reg;
        wlast_next         = wlast_reg;
        hlast_next         = hlast_reg;
        st1_next           = '0;

        if (pix_go) begin
            st1_next.pix     = 1'b1;
            st1_next.top_dup = (row_reg == CW'(1));
            st1_next.x       = col_reg;
            st1_next.raw     = s_tdata;
            st1_next.a_en    = (row_reg != '0) && (col_reg != '0);
            st1_next.b_en    = (row_reg != '0) && row_end;
            st1_next.lc      = (col_reg == COL_W'(1));
            st1_next.a_col   = CW'(col_reg - 1'b1);
            st1_next.a_row   = row_reg - 1'b1;
            st1_next.b_col   = CW'(col_reg);
        end else if (drn_go) begin
            st1_next.drn     = 1'b1;
            st1_next.first   = (dcol_reg == '0);
            st1_next.a_en    = 1'b1;
            st1_next.fe      = drain_last;
            st1_next.a_col   = CW'(dcol_reg);
            st1_next.a_row   = row_reg;
        end

        if (cfg_hit) begin
            col_next           = '0;
            row_next           = '0;
            dcol_next          = '0;
            drain_pending_next = 1'b0;
            if (cfg_index == bdm_pkg::REG_FRAME_WIDTH) begin
                priority if (fw_ext < EW'(2)) begin
                    wlast_next = COL_W'(1);
                end else if (fw_ext > EW'(MAX_WIDTH)) begin
                    wlast_next = COL_W'(MAX_WIDTH - 1);
                end else begin
                    wlast_next = COL_W'(fw_ext - 1'b1);
                end
            end else begin
                priority if (fh < bdm_pkg::CFG_W'(2)) begin
                    hlast_next = CW'(1);
                end else if (fh > bdm_pkg::CFG_W'(bdm_pkg::MAX_HEIGHT)) begin
                    hlast_next = CW'(bdm_pkg::MAX_HEIGHT - 1);
                end else begin
                    hlast_next = CW'(fh - 1'b1);
                end
            end
        end else if (pix_go) begin
            if (row_end) begin
                col_next = '0;
                if (row_reg == hlast_reg) begin
                    drain_pending_next = 1'b1;
                end else begin
                    row_next = row_reg + 1'b1;
                end
            end else begin
                col_next = col_reg + 1'b1;
            end
        end else if (drn_go) begin
            if (drain_last) begin
                drain_pending_next = 1'b0;
                dcol_next          = '0;
                row_next           = '0;
                col_next           = '0;
            end else begin
                dcol_next = dcol_reg + 1'b1;
            end
        end
    end

    // stage 1: line store data arrives, window shifts, stores update
    bdm_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_older (
        .aclk      (aclk),
        .wr_en     (st1_reg.pix),
        .wr_addr   (st1_reg.x),
        .wr_data   (s1_mid),
        .rd_addr_a (rd_addr_a),
        .rd_data_a (old_a),
        .rd_addr_b (dcol_reg),
        .rd_data_b (old_b)
    );

    bdm_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_newer (
        .aclk      (aclk),
        .wr_en     (st1_reg.pix),
        .wr_addr   (st1_reg.x),
        .wr_data   (st1_reg.raw),
        .rd_addr_a (rd_addr_a),
        .rd_data_a (new_a),
        .rd_addr_b (dcol_reg),
        .rd_data_b (new_b)
    );

    // while row 1 arrives, output row 0 has no row above: repeat the middle row
    assign s1_mid   = new_a;
    assign s1_top   = st1_reg.top_dup ? new_a : old_a;
    assign s1_col_a = st1_reg.pix ? '{top: s1_top, mid: s1_mid, bot: st1_reg.raw}
                                  : '{top: old_a, mid: new_a, bot: new_a};
    assign s1_col_b = '{top: old_b, mid: new_b, bot: new_b};
    assign win_en   = st1_reg.pix || st1_reg.drn;
    assign win_load = st1_reg.drn && st1_reg.first;

    bdm_cell u_cell0 (
        .aclk        (aclk),
        .i_en        (win_en),
        .i_load      (win_load),
        .i_load_col  (s1_col_b),
        .i_shift_col (c1),
        .o_col       (c0),
        .o_vsum      (v0)
    );

    bdm_cell u_cell1 (
        .aclk        (aclk),
        .i_en        (win_en),
        .i_load      (win_load),
        .i_load_col  (s1_col_b),
        .i_shift_col (c2),
        .o_col       (c1),
        .o_vsum      (v1)
    );

    bdm_cell u_cell2 (
        .aclk        (aclk),
        .i_en        (win_en),
        .i_load      (1'b0),
        .i_load_col  (s1_col_b),
        .i_shift_col (s1_col_a),
        .o_col       (c2),
        .o_vsum      (v2)
    );

    // stage 2: interpolate and queue
    bdm_interp u_interp_a (
        .i_left        (st2_reg.lc ? c1 : c0),
        .i_center      (c1),
        .i_right       (c2),
        .i_left_vsum   (st2_reg.lc ? v1 : v0),
        .i_center_vsum (v1),
        .i_right_vsum  (v2),
        .i_x_odd       (st2_reg.a_col[0]),
        .i_y_odd       (st2_reg.a_row[0]),
        .o_rgb         (rgb_a)
    );

    bdm_interp u_interp_b (
        .i_left        (c1),
        .i_center      (c2),
        .i_right       (c2),
        .i_left_vsum   (v1),
        .i_center_vsum (v2),
        .i_right_vsum  (v2),
        .i_x_odd       (st2_reg.b_col[0]),
        .i_y_odd       (st2_reg.a_row[0]),
        .o_rgb         (rgb_b)
    );

    assign res_a  = '{rgb: rgb_a, col: st2_reg.a_col, row: st2_reg.a_row, fe: st2_reg.fe};
    assign res_b  = '{rgb: rgb_b, col: st2_reg.b_col, row: st2_reg.a_row, fe: 1'b0};
    assign push_n = n2;
    assign oq_pop = m_tvalid && m_tready;

    always_ff @(posedge aclk) begin
        if (st2_reg.a_en) begin
            oq_mem_reg[oq_wr_reg] <= res_a;
            if (st2_reg.b_en) begin
                oq_mem_reg[oq_wr_reg + 1'b1] <= res_b;
            end
        end else if (st2_reg.b_en) begin
            oq_mem_reg[oq_wr_reg] <= res_b;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg           <= '0;
            row_reg           <= '0;
            dcol_reg          <= '0;
            drain_pending_reg <= 1'b0;
            wlast_reg         <= COL_W'(RST_W - 1);
            hlast_reg         <= CW'(bdm_pkg::RESET_HEIGHT - 1);
            st1_reg           <= '0;
            st2_reg           <= '0;
            oq_wr_reg         <= '0;
            oq_rd_reg         <= '0;
            oq_count_reg      <= '0;
        end else begin
            col_reg           <= col_next;
            row_reg           <= row_next;
            dcol_reg          <= dcol_next;
            drain_pending_reg <= drain_pending_next;
            wlast_reg         <= wlast_next;
            hlast_reg         <= hlast_next;
            st1_reg           <= st1_next;
            st2_reg           <= st1_reg;
            oq_wr_reg         <= oq_wr_reg + QA'(push_n);
            oq_rd_reg         <= oq_rd_reg + QA'(oq_pop);
            oq_count_reg      <= oq_count_reg + (QA+1)'(push_n) - (QA+1)'(oq_pop);
        end
    end

    assign m_tvalid = (oq_count_reg != '0);
    assign m_tdata  = {oq_mem_reg[oq_rd_reg].row, oq_mem_reg[oq_rd_reg].col,
                       oq_mem_reg[oq_rd_reg].rgb.blue, oq_mem_reg[oq_rd_reg].rgb.green,
                       oq_mem_reg[oq_rd_reg].rgb.red};
    assign m_tlast  = oq_mem_reg[oq_rd_reg].fe;

    `BDM_ASSERT_NOW(a_oq_no_overflow, push_n != 2'd0, ((QA+2)'(oq_count_reg) + (QA+2)'(push_n)) <= ((QA+2)'(QD) + (QA+2)'(oq_pop)), "result queue overflow")
    `BDM_ASSERT_NEXT(a_drop_while_draining, s_tvalid && s_tready && !s_tuser && drain_pending_reg, !st1_reg.pix, "pixel beat entered during drain")
    `BDM_ASSERT_NOW(a_row_end_pair, st2_reg.b_en, st2_reg.a_en && st2_reg.pix, "row end beat without its left neighbor")

endmodule

@@ tb/sv/tb.sv @@
// Self-checking bench for bayer_rggb_bilinear_demosaic: streams RGGB frames, drain ticks
// and config writes, predicts every RGB beat in-bench and checks the m_ side field by field.
// Depends on bdm_pkg and the demosaic RTL only.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bdm_pkg::*;

    localparam int          RAND_ITEMS  = 1850;
    localparam int          SETTLE_CYC  = 8;
    localparam int          MAX_REPORTS = 60;
    localparam int unsigned CYCLE_LIMIT = 3_000_000;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(15);

    typedef struct packed {
        logic       drain;
        logic [7:0] raw;
    } raw_beat_t;

    // same bit order as {m_tlast, m_tdata}
    typedef struct packed {
        logic                frame_end;
        logic [COORD_W-1:0]  row;
        logic [COORD_W-1:0]  col;
        logic [PIX_W-1:0]    blue;
        logic [PIX_W-1:0]    green;
        logic [PIX_W-1:0]    red;
    } rgb_beat_t;

    logic                 aclk;
    logic                 aresetn   = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data  = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata   = '0;   // [7:0] raw_value
    logic                 s_tuser   = 1'b0; // [0] req_type
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [47:0]          m_tdata;          // red, green, blue, out_col, out_row
    logic                 m_tlast;          // frame_end

    bayer_rggb_bilinear_demosaic DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always begin
        aclk = 1'b1;
        #6;
        aclk = 1'b0;
        #6;
    end

    // demosaic predictor state
    logic [CFG_W-1:0] cfg_width;
    logic [CFG_W-1:0] cfg_height;
    logic [7:0]       prev2_row [0:MAX_WIDTH_DEF-1];
    logic [7:0]       prev_row  [0:MAX_WIDTH_DEF-1];
    logic [8:0][7:0]  kern;
    int               col_pos;
    int               row_pos;
    bit               flush_pending;
    int               flush_col;

    raw_beat_t        pixel_q [$];
    rgb_beat_t        rgb_expect_q [$];

    int               fail_cnt     = 0;
    int               src_idle_pct = 10;
    int               snk_idle_pct = 10;
    int               src_gap      = 0;
    int               snk_gap      = 0;
    int               rand_items   = 0;
    int unsigned      cycle_cnt    = 0;
    raw_beat_t        nxt;

    function automatic int sat_dim(int v);
        if (v < 2) return 2;
        if (v > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
        return v;
    endfunction

    // p: nw n ne w c e sw s se
    function automatic rgb_beat_t bilinear_rgb(int x, int y, logic [8:0][7:0] p, logic fe);
        rgb_beat_t b;
        int        orth, diag, hor, ver;
        orth = p[1] + p[7] + p[3] + p[5];
        diag = p[0] + p[2] + p[6] + p[8];
        hor  = (p[3] + p[5] + 1) >> 1;
        ver  = (p[1] + p[7] + 1) >> 1;
        b.col       = x[COORD_W-1:0];
        b.row       = y[COORD_W-1:0];
        b.frame_end = fe;
        if (x % 2 == 0 && y % 2 == 0) begin
            b.red   = p[4];
            b.green = 8'((orth + 2) >> 2);
            b.blue  = 8'((diag + 2) >> 2);
        end else if (x % 2 == 1 && y % 2 == 1) begin
            b.blue  = p[4];
            b.green = 8'((orth + 2) >> 2);
            b.red   = 8'((diag + 2) >> 2);
        end else begin
            b.green = p[4];
            if (y % 2 == 0) begin
                b.red  = 8'(hor);
                b.blue = 8'(ver);
            end else begin
                b.blue = 8'(hor);
                b.red  = 8'(ver);
            end
        end
        return b;
    endfunction

    task automatic restart_frame();
        kern          = '0;
        col_pos       = 0;
        row_pos       = 0;
        flush_pending = 1'b0;
        flush_col     = 0;
    endtask

    task automatic demosaic_predict(input logic drain, input logic [7:0] raw);
        int              w, h, x, y, xm, xp, lc, r;
        logic [7:0]      top, mid;
        logic [8:0][7:0] p;
        w = sat_dim(cfg_width);
        h = sat_dim(cfg_height);
        if (drain) begin
            if (!flush_pending) return;
            x = flush_col;
            y = row_pos;
            if (x >= w) x = w - 1;
            xm = (x == 0) ? 0 : x - 1;
            xp = (x + 1 < w) ? x + 1 : w - 1;
            p[0] = prev2_row[xm];
            p[1] = prev2_row[x];
            p[2] = prev2_row[xp];
            p[3] = prev_row[xm];
            p[4] = prev_row[x];
            p[5] = prev_row[xp];
            p[6] = p[3];
            p[7] = p[4];
            p[8] = p[5];
            if (x + 1 >= w) begin
                rgb_expect_q.push_back(bilinear_rgb(x, y, p, 1'b1));
                flush_pending = 1'b0;
                flush_col     = 0;
                row_pos       = 0;
                col_pos       = 0;
            end else begin
                rgb_expect_q.push_back(bilinear_rgb(x, y, p, 1'b0));
                flush_col = x + 1;
            end
            return;
        end
        if (flush_pending) return;

        x = col_pos;
        y = row_pos;
        if (x >= w) x = w - 1;
        mid = prev_row[x];
        top = (y == 1) ? mid : prev2_row[x];
        for (r = 0; r < 3; r++) begin
            kern[r*3]   = kern[r*3+1];
            kern[r*3+1] = kern[r*3+2];
        end
        kern[2] = top;
        kern[5] = mid;
        kern[8] = raw;
        prev2_row[x] = mid;
        prev_row[x]  = raw;

        if (y >= 1 && x >= 1) begin
            lc = (x == 1) ? 1 : 0;
            for (r = 0; r < 3; r++) begin
                p[r*3]   = kern[r*3+lc];
                p[r*3+1] = kern[r*3+1];
                p[r*3+2] = kern[r*3+2];
            end
            rgb_expect_q.push_back(bilinear_rgb(x - 1, y - 1, p, 1'b0));
        end
        if (y >= 1 && x + 1 >= w) begin
            for (r = 0; r < 3; r++) begin
                p[r*3]   = kern[r*3+1];
                p[r*3+1] = kern[r*3+2];
                p[r*3+2] = kern[r*3+2];
            end
            rgb_expect_q.push_back(bilinear_rgb(x, y - 1, p, 1'b0));
        end

        if (x + 1 >= w) begin
            col_pos = 0;
            if (y + 1 >= h) flush_pending = 1'b1;
            else row_pos = y + 1;
        end else begin
            col_pos = x + 1;
        end
    endtask

    task automatic check_field(string fld, int want, int got, rgb_beat_t ref_b);
        if (want != got) begin
            fail_cnt++;
            if (fail_cnt <= MAX_REPORTS)
                $display("%0t ns: %s mismatch at row %0d col %0d: expected %0d, actual %0d",
                         $time, fld, ref_b.row, ref_b.col, want, got);
        end
    endtask

    // input driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            src_gap = 0;
        end else begin
            if (s_tvalid && s_tready) demosaic_predict(s_tuser, s_tdata);
            if (!s_tvalid || s_tready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_tvalid <= 1'b0;
                end else if (pixel_q.size() > 0) begin
                    nxt = pixel_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= nxt.drain;
                    s_tdata  <= nxt.raw;
                    if (src_idle_pct > 0 && $urandom_range(1, 100) <= src_idle_pct)
                        src_gap = $urandom_range(1, 17);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin
        rgb_beat_t want, got;
        if (!aresetn) begin
            m_tready <= 1'b0;
            snk_gap = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = {m_tlast, m_tdata};
                if (rgb_expect_q.size() == 0) begin
                    fail_cnt++;
                    if (fail_cnt <= MAX_REPORTS)
                        $display("%0t ns: unexpected beat: expected none, actual %h last %b",
                                 $time, m_tdata, m_tlast);
                end else begin
                    want = rgb_expect_q.pop_front();
                    check_field("red",       want.red,       got.red,       want);
                    check_field("green",     want.green,     got.green,     want);
                    check_field("blue",      want.blue,      got.blue,      want);
                    check_field("out_col",   want.col,       got.col,       want);
                    check_field("out_row",   want.row,       got.row,       want);
                    check_field("frame_end", want.frame_end, got.frame_end, want);
                end
            end
            if (snk_gap > 0) begin
                snk_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (snk_idle_pct > 0 && $urandom_range(1, 100) <= snk_idle_pct)
                    snk_gap = $urandom_range(1, 17);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic logic [7:0] rand_raw();
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic queue_beat(input logic drain, input logic [7:0] raw);
        pixel_q.push_back('{drain: drain, raw: raw});
        rand_items++;
    endtask

    task automatic settle();
        do @(posedge aclk);
        while (pixel_q.size() != 0 || s_tvalid || rgb_expect_q.size() != 0);
        repeat (SETTLE_CYC) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_W'(val);
        do @(posedge aclk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_FRAME_WIDTH) cfg_width = CFG_W'(val);
        else if (idx == REG_FRAME_HEIGHT) cfg_height = CFG_W'(val);
        else return;
        restart_frame();
    endtask

    // cut: stop partway, no drain
    task automatic send_frame(input int w, input int h, input bit cut);
        int stop_at, n;
        stop_at = cut ? $urandom_range(1, w * h - 1) : w * h;
        for (n = 0; n < stop_at; n++) begin
            if ($urandom_range(0, 40) == 0) queue_beat(1'b1, rand_raw());
            queue_beat(1'b0, rand_raw());
        end
        if (cut) return;
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) queue_beat(1'b0, rand_raw());
        repeat (w) queue_beat(1'b1, rand_raw());
        if ($urandom_range(0, 3) == 0) queue_beat(1'b1, rand_raw());
    endtask

    initial begin
        int  w_raw, h_raw, frame_w, frame_h, i;
        bit  dirty, cut;

        cfg_width  = CFG_W'(RESET_WIDTH);
        cfg_height = CFG_W'(RESET_HEIGHT);
        for (i = 0; i < MAX_WIDTH_DEF; i++) begin
            prev2_row[i] = '0;
            prev_row[i]  = '0;
        end
        restart_frame();

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // reset geometry into row 1, with a full pause and an unused-index write mid-row
        queue_beat(1'b1, 8'hFF);
        repeat (640 + 5) queue_beat(1'b0, rand_raw());
        settle();
        write_reg(REG_UNUSED, 13'h1555);
        repeat (5) queue_beat(1'b0, rand_raw());
        settle();

        // 2x2 via saturated low values
        write_reg(REG_FRAME_WIDTH, 0);
        write_reg(REG_FRAME_HEIGHT, 1);
        queue_beat(1'b0, 8'h00);
        queue_beat(1'b0, 8'hFF);
        queue_beat(1'b0, 8'hFF);
        queue_beat(1'b0, 8'h00);
        queue_beat(1'b0, 8'hA5);   // dropped, drain pending
        queue_beat(1'b1, 8'h00);
        queue_beat(1'b1, 8'hFF);
        queue_beat(1'b1, 8'h00);   // no drain pending
        queue_beat(1'b0, 8'h55);
        queue_beat(1'b0, 8'hAA);
        queue_beat(1'b0, 8'hAA);
        queue_beat(1'b0, 8'h55);
        queue_beat(1'b1, 8'h00);   // drain left half done
        settle();
        write_reg(REG_FRAME_WIDTH, 3);  // cancels the drain
        queue_beat(1'b0, 8'hFF);
        queue_beat(1'b0, 8'h00);
        queue_beat(1'b0, 8'h80);
        queue_beat(1'b0, 8'h01);
        queue_beat(1'b0, 8'hFE);
        queue_beat(1'b0, 8'h7F);
        queue_beat(1'b0, 8'h3C);
        repeat (3) queue_beat(1'b1, 8'h00);
        settle();

        // saturated high width, then saturated high height on a 2-wide frame
        write_reg(REG_FRAME_WIDTH, 13'h1FFF);
        repeat (160) queue_beat(1'b0, rand_raw());
        settle();
        write_reg(REG_FRAME_WIDTH, 2);
        write_reg(REG_FRAME_HEIGHT, 13'h1FFF);
        repeat (2 * 40) queue_beat(1'b0, rand_raw());
        queue_beat(1'b1, 8'h00);   // no drain pending
        settle();

        frame_w    = 2;
        frame_h    = MAX_HEIGHT;
        dirty      = 1'b1;
        while (rand_items < RAND_ITEMS) begin
            settle();
            if (rand_items > RAND_ITEMS * 4 / 5) begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end else begin
                src_idle_pct = $urandom_range(0, 2) * 12;
                snk_idle_pct = $urandom_range(0, 2) * 12;
            end
            w_raw = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 70) : $urandom_range(2, 12);
            h_raw = $urandom_range(2, 5);
            if ($urandom_range(0, 15) == 0) w_raw = $urandom_range(0, 1);
            if ($urandom_range(0, 15) == 0) h_raw = $urandom_range(0, 1);
            if (dirty || frame_h > 8 || $urandom_range(0, 3) != 0) begin
                case ($urandom_range(0, 2))
                    0: begin
                        write_reg(REG_FRAME_WIDTH, w_raw);
                        frame_w = sat_dim(w_raw);
                    end
                    1: begin
                        write_reg(REG_FRAME_HEIGHT, h_raw);
                        frame_h = sat_dim(h_raw);
                    end
                    default: begin
                        write_reg(REG_FRAME_WIDTH, w_raw);
                        write_reg(REG_FRAME_HEIGHT, h_raw);
                        frame_w = sat_dim(w_raw);
                        frame_h = sat_dim(h_raw);
                    end
                endcase
            end
            if (frame_h > 8) begin
                write_reg(REG_FRAME_HEIGHT, h_raw);
                frame_h = sat_dim(h_raw);
            end
            cut = ($urandom_range(0, 7) == 0);
            send_frame(frame_w, frame_h, cut);
            dirty = cut;
        end

        settle();
        if (rgb_expect_q.size() != 0) fail_cnt++;
        if (fail_cnt == 0) $display("Test completed successfully");
        else $display("Test completed with failures");
        $finish;
    end

endmodule

@@ bayer_rggb_bilinear_demosaic.f @@
+incdir+sv
sv/bdm_pkg.sv
sv/bdm_ram.sv
sv/bdm_cell.sv
sv/bdm_interp.sv
sv/bayer_rggb_bilinear_demosaic.sv
tb/sv/tb.sv
